// ===== src/rdcg_pkg.sv =====
// Shared types and constants for the revolving-door combination generator.
package rdcg_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = 7;
  localparam int T_W          = 6;
  localparam int MASK_W       = 64;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_N_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T_SIZE  = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_LD2,
    ST_FIRST,
    ST_R4,
    ST_R4B,
    ST_R5,
    ST_WR2,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic fire;
    logic restart;
  } seq_req_t;

  typedef struct packed {
    logic              valid;
    logic [MASK_W-1:0] mask;
    logic              exhausted;
  } seq_res_t;

endpackage

// ===== src/rdcg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rdcg_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rdcg_seq.sv =====
// Sequencer and datapath stepping Algorithm R over the index RAM.
module rdcg_seq import rdcg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  seq_req_t          req,
  input  logic              cfg_hit,
  input  logic [IDX_W-1:0]  n_total,
  input  logic [T_W-1:0]    t_size,
  input  logic              out_free,
  output logic              idle,
  output seq_res_t          res
);

  seq_state_t state_r, state_nxt;
  logic              done_r, done_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [IDX_W-1:0]  a_r, a_nxt;
  logic [IDX_W-1:0]  b_r, b_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  wa2_r, wa2_nxt;
  logic [IDX_W-1:0]  wd2_r, wd2_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  logic [IDX_W-1:0]  t7, t_end;
  logic              sizes_ok, first_ok, r4_end, r4_hit, r4_last, r5_hit, init_last;

  function automatic logic [MASK_W-1:0] bit_of(input logic [IDX_W-1:0] v);
    bit_of = {{(MASK_W-1){1'b0}}, 1'b1} << v[5:0];
  endfunction

  rdcg_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_ELEMENTS + 1)
  ) u_idx_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign t7        = {1'b0, t_size};
  assign t_end     = t7 + 7'd1;
  assign sizes_ok  = (t_size >= 6'd2) && (t7 < n_total) && (n_total <= 7'(MAX_ELEMENTS));
  assign first_ok  = t_size[0] ? ((a_r + 7'd1) < ram_rdata) : (a_r != '0);
  assign r4_end    = j_r > t7;
  assign r4_hit    = b_r >= j_r;
  assign r4_last   = (j_r + 7'd1) > t7;
  assign r5_hit    = (b_r + 7'd1) < ram_rdata;
  assign init_last = k_r == t_end;

  assign idle          = state_r == ST_IDLE;
  assign res.valid     = (state_r == ST_OUT) && out_free;
  assign res.mask      = done_r ? '0 : mask_r;
  assign res.exhausted = done_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req.fire) begin
          if (req.restart) begin
            state_nxt = sizes_ok ? ST_INIT : ST_OUT;
          end else begin
            state_nxt = done_r ? ST_OUT : ST_LD2;
          end
        end
      end
      ST_INIT:  state_nxt = init_last ? ST_OUT : ST_INIT;
      ST_LD2:   state_nxt = ST_FIRST;
      ST_FIRST: begin
        if (first_ok) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = t_size[0] ? ST_R4 : ST_R5;
        end
      end
      ST_R4: begin
        if (r4_end) begin
          state_nxt = ST_OUT;
        end else if (r4_hit) begin
          state_nxt = ST_WR2;
        end else if (r4_last) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_R4B;
        end
      end
      ST_R4B:   state_nxt = ST_R5;
      ST_R5:    state_nxt = r5_hit ? ST_WR2 : ST_R4;
      ST_WR2:   state_nxt = ST_OUT;
      ST_OUT:   state_nxt = out_free ? ST_IDLE : ST_OUT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    done_nxt  = done_r;
    mask_nxt  = mask_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    wa2_nxt   = wa2_r;
    wd2_nxt   = wd2_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = 7'd1;
        if (req.fire && req.restart) begin
          done_nxt = !sizes_ok;
          mask_nxt = ~({MASK_W{1'b1}} << t_size);
          k_nxt    = 7'd1;
        end
      end
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = init_last ? n_total : (k_r - 7'd1);
        k_nxt     = k_r + 7'd1;
      end
      ST_LD2: begin
        ram_raddr = 7'd2;
        a_nxt     = ram_rdata;
        j_nxt     = 7'd2;
      end
      ST_FIRST: begin
        b_nxt     = ram_rdata;
        ram_raddr = j_r + 7'd1;
        if (first_ok) begin
          ram_we    = 1'b1;
          ram_waddr = 7'd1;
          ram_wdata = t_size[0] ? (a_r + 7'd1) : (a_r - 7'd1);
          mask_nxt  = (mask_r & ~bit_of(a_r)) | bit_of(ram_wdata);
        end
      end
      ST_R4: begin
        ram_raddr = j_r + 7'd1;
        if (r4_end) begin
          done_nxt = 1'b1;
        end else if (r4_hit) begin
          ram_we    = 1'b1;
          ram_waddr = j_r;
          ram_wdata = b_r - 7'd1;
          wa2_nxt   = j_r - 7'd1;
          wd2_nxt   = j_r - 7'd2;
          mask_nxt  = (mask_r & ~(bit_of(a_r) | bit_of(b_r)))
                    | bit_of(b_r - 7'd1) | bit_of(j_r - 7'd2);
        end else if (r4_last) begin
          done_nxt = 1'b1;
        end else begin
          a_nxt = b_r;
          j_nxt = j_r + 7'd1;
        end
      end
      ST_R4B: begin
        b_nxt     = ram_rdata;
        ram_raddr = j_r + 7'd1;
      end
      ST_R5: begin
        if (r5_hit) begin
          ram_we    = 1'b1;
          ram_waddr = j_r - 7'd1;
          ram_wdata = b_r;
          wa2_nxt   = j_r;
          wd2_nxt   = b_r + 7'd1;
          mask_nxt  = (mask_r & ~bit_of(a_r)) | bit_of(b_r + 7'd1);
        end else begin
          j_nxt = j_r + 7'd1;
          a_nxt = b_r;
          b_nxt = ram_rdata;
        end
      end
      ST_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = wa2_r;
        ram_wdata = wd2_r;
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
    if (cfg_hit) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    wa2_r  <= wa2_nxt;
    wd2_r  <= wd2_nxt;
  end

  a_init_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INIT |-> k_r <= t_end)
    else $error("init sweep ran past c[t+1]");

  a_r5_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_R5 |-> j_r <= t7)
    else $error("scan read beyond c[t+1]");

  a_restart_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && req.fire && req.restart && sizes_ok && !cfg_hit) |=> !done_r)
    else $error("valid restart left generator exhausted");

  a_mask_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !done_r) |-> $countones(mask_r) == int'(t_size))
    else $error("combination word has wrong element count");

endmodule

// ===== src/revolving_door_combination_generator_unit.sv =====
// Top level: config registers, input handshake and output word register.
//
// Usage:
//   cfg channel writes n_total (index 0) and t_size (index 1); any write to
//   either ends the running enumeration until the next restart word.
//   in channel: in_restart=1 loads {0..t-1}, in_restart=0 steps to the next
//   combination in revolving-door order. Each input word yields one output.
//   out channel: out_combo_mask holds the set, out_exhausted flags the end
//   (mask zero then). Sizes outside 2 <= t < n <= 64 give exhausted at once.
// Flow: a restart writes t+1 index RAM entries; bad sizes or an exhausted
//   advance go straight to the output word; an advance moves c[1] when it
//   can, else scans the index with R4 and R5 tests until one hits or the
//   scan runs off the end. The output word is registered as in_ready
//   returns. One word is in flight at a time.
// Reset: generator comes up exhausted, n_total=8, t_size=3; the index RAM is
//   not cleared and is read only after a restart has filled it.
// Stall: a finished word holds in the output register; the sequencer waits
//   to hand over its next word until the register is taken.
module revolving_door_combination_generator_unit import rdcg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MASK_W-1:0]    out_combo_mask,
  output logic                 out_exhausted,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [IDX_W-1:0]     cfg_data
);

  logic [IDX_W-1:0]  n_total_r, n_total_nxt;
  logic [T_W-1:0]    t_size_r, t_size_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_mask_r, out_mask_nxt;
  logic              out_exh_r, out_exh_nxt;
  logic              cfg_fire, cfg_hit, out_free, seq_idle;
  seq_req_t          req;
  seq_res_t          res;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && ((cfg_index == REG_N_TOTAL) || (cfg_index == REG_T_SIZE));
  assign in_ready  = seq_idle;
  assign req.fire    = in_valid && in_ready;
  assign req.restart = in_restart;
  assign out_free  = !out_valid_r || out_ready;

  rdcg_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .cfg_hit(cfg_hit),
    .n_total(n_total_r),
    .t_size (t_size_r),
    .out_free(out_free),
    .idle   (seq_idle),
    .res    (res)
  );

  always_comb begin
    n_total_nxt = n_total_r;
    t_size_nxt  = t_size_r;
    if (cfg_fire) begin
      unique case (cfg_index)
        REG_N_TOTAL: n_total_nxt = cfg_data;
        REG_T_SIZE:  t_size_nxt  = cfg_data[T_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_mask_nxt  = out_mask_r;
    out_exh_nxt   = out_exh_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid) begin
      out_valid_nxt = 1'b1;
      out_mask_nxt  = res.mask;
      out_exh_nxt   = res.exhausted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_total_r   <= 7'd8;
      t_size_r    <= 6'd3;
      out_valid_r <= 1'b0;
    end else begin
      n_total_r   <= n_total_nxt;
      t_size_r    <= t_size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mask_r <= out_mask_nxt;
    out_exh_r  <= out_exh_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_combo_mask = out_mask_r;
  assign out_exhausted  = out_exh_r;

endmodule
